// ===== sv/assert_macros.svh =====
// Assertion macros shared by the outline core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`endif

// ===== sv/blo_pkg.sv =====
// Shared constants and types of the label outline core.
package blo_pkg;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_LABEL_BITS = 6;

   localparam int IMAGE_WIDTH_W  = 11;
   localparam int IMAGE_HEIGHT_W = 16;
   localparam int ENABLE_W       = 6;
   localparam int ROW_CNT_W      = IMAGE_HEIGHT_W + 1;
   localparam int CSR_ADDR_W     = 2;
   localparam int CSR_DATA_W     = 16;
   localparam int FLAGS_PER_LABEL = 4;

   localparam int RESET_WIDTH = 1024;
   localparam logic [IMAGE_HEIGHT_W-1:0] RESET_HEIGHT = 16'd1024;
   localparam logic [ENABLE_W-1:0]       RESET_ENABLE = 6'h3f;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_BIT_ENABLE   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic emit;
      logic last;
      logic has_w;
      logic has_e;
      logic has_s;
      logic has_n;
   } border_type;

endpackage

// ===== sv/bitmask_label_outline_core.sv =====
// Top level of the label outline core: registers, frame counters, line buffer RAM.
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_stall  req_label_value, req_pad
//   rsp       out        rsp_valid/rsp_stall  rsp_pixel_col/row, edge/corner flags, frame_last
//   csr       in         csr_valid/csr_ready  csr_index, csr_wdata
//
// One item per cycle unless a result is stalled, set by the read-modify-write of the line buffer
// RAM (one read port, one write port, forwarding for back-to-back use of one column).
// A result passes the RAM read stage, then the result register, before it leaves.
// The first image_width+1 items of a frame give no result.
// Reset clears control state only; stale line buffer contents are always masked.
// A stalled result holds one more item in the read stage, then req_stall rises.
`include "assert_macros.svh"

module bitmask_label_outline_core #(
   parameter int MAX_WIDTH  = blo_pkg::DEF_MAX_WIDTH,
   parameter int LABEL_BITS = blo_pkg::DEF_LABEL_BITS
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           req_valid,
   output logic                                           req_stall,
   input  logic [LABEL_BITS-1:0]                          req_label_value,
   input  logic                                           req_pad,
   output logic                                           rsp_valid,
   input  logic                                           rsp_stall,
   output logic [$clog2(MAX_WIDTH)-1:0]                   rsp_pixel_col,
   output logic [blo_pkg::IMAGE_HEIGHT_W-1:0]             rsp_pixel_row,
   output logic [blo_pkg::FLAGS_PER_LABEL*LABEL_BITS-1:0] rsp_edge_flags,
   output logic [blo_pkg::FLAGS_PER_LABEL*LABEL_BITS-1:0] rsp_corner_flags,
   output logic                                           rsp_frame_last,
   input  logic                                           csr_valid,
   output logic                                           csr_ready,
   input  logic [blo_pkg::CSR_ADDR_W-1:0]                 csr_index,
   input  logic [blo_pkg::CSR_DATA_W-1:0]                 csr_wdata
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int WID_W  = $clog2(MAX_WIDTH + 1);
   localparam int ROW_W  = blo_pkg::ROW_CNT_W;
   localparam int HGT_W  = blo_pkg::IMAGE_HEIGHT_W;
   localparam int WORD_W = 2 * LABEL_BITS;

   logic [WID_W-1:0]      width_ff, width_in;
   logic [HGT_W-1:0]      height_ff, height_in;
   logic [LABEL_BITS-1:0] enable_ff, enable_in;
   logic [COL_W-1:0]      col_ff, col_in;
   logic [ROW_W-1:0]      row_ff, row_in;

   logic                  s1_valid_ff, s1_valid_in;
   logic [LABEL_BITS-1:0] s1_value_ff;
   logic [COL_W-1:0]      s1_addr_ff;
   logic [COL_W-1:0]      s1_col_ff;
   logic [HGT_W-1:0]      s1_row_ff;
   blo_pkg::border_type   s1_border_ff;
   logic                  fwd_ff, fwd_in;
   logic [WORD_W-1:0]     fwd_data_ff;

   logic                             accept, s1_fire, out_free, csr_wr;
   logic [LABEL_BITS-1:0]            pixel;
   logic                             col_zero;
   logic [COL_W-1:0]                 cc;
   logic [HGT_W-1:0]                 cr;
   logic [WID_W-1:0]                 col_inc;
   blo_pkg::border_type              border_s0;
   logic [blo_pkg::IMAGE_WIDTH_W-1:0] w_field;
   logic [WID_W-1:0]                 w_clamped;
   logic [HGT_W-1:0]                 h_field;
   logic [blo_pkg::ENABLE_W+31:0]    en_wide, en_reset_wide;
   logic [WORD_W-1:0]                rd_word, old_word, wr_word;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;
   assign s1_fire   = s1_valid_ff && (!s1_border_ff.emit || out_free);
   assign req_stall = s1_valid_ff && !s1_fire;
   assign accept    = req_valid && !req_stall;

   // position of the incoming item and the pixel it completes
   always_comb begin
      pixel = (req_pad || row_ff >= ROW_W'(height_ff)) ? '0 : req_label_value;
      col_zero = (col_ff == '0);
      cc = col_zero ? COL_W'(width_ff - WID_W'(1)) : col_ff - COL_W'(1);
      cr = col_zero ? HGT_W'(row_ff - ROW_W'(2)) : HGT_W'(row_ff - ROW_W'(1));
      border_s0.emit  = (row_ff >= ROW_W'(2)) || (row_ff == ROW_W'(1) && !col_zero);
      border_s0.has_w = (cc != '0);
      border_s0.has_e = (WID_W'(cc) != width_ff - WID_W'(1));
      border_s0.has_s = (cr != '0);
      border_s0.has_n = (cr != height_ff - HGT_W'(1));
      border_s0.last  = !border_s0.has_e && !border_s0.has_n;
      col_inc = WID_W'(col_ff) + WID_W'(1);
   end

   always_comb begin
      w_field = csr_wdata[blo_pkg::IMAGE_WIDTH_W-1:0];
      if (w_field == '0) begin
         w_clamped = WID_W'(1);
      end else if (32'(w_field) > 32'(MAX_WIDTH)) begin
         w_clamped = WID_W'(MAX_WIDTH);
      end else begin
         w_clamped = WID_W'(w_field);
      end
      h_field = csr_wdata[HGT_W-1:0];
      if (h_field == '0) begin
         h_field = HGT_W'(1);
      end
      en_wide       = {32'd0, csr_wdata[blo_pkg::ENABLE_W-1:0]};
      en_reset_wide = {32'd0, blo_pkg::RESET_ENABLE};
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      enable_in = enable_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      if (accept) begin
         if (border_s0.emit && border_s0.last) begin
            col_in = '0;
            row_in = '0;
         end else if (col_inc >= width_ff) begin
            col_in = '0;
            row_in = row_ff + ROW_W'(1);
         end else begin
            col_in = COL_W'(col_inc);
         end
      end
      if (csr_wr) begin
         case (csr_index)
            blo_pkg::CSR_IMAGE_WIDTH: begin
               width_in = w_clamped;
               col_in   = '0;
               row_in   = '0;
            end
            blo_pkg::CSR_IMAGE_HEIGHT: begin
               height_in = h_field;
               col_in    = '0;
               row_in    = '0;
            end
            blo_pkg::CSR_BIT_ENABLE: begin
               enable_in = en_wide[LABEL_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // read stage bookkeeping and same-column forwarding
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
      fwd_in   = accept && s1_fire && (s1_addr_ff == col_ff);
      old_word = fwd_ff ? fwd_data_ff : rd_word;
      wr_word  = {old_word[LABEL_BITS-1:0], s1_value_ff};
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_value_ff  <= pixel;
         s1_addr_ff   <= col_ff;
         s1_col_ff    <= cc;
         s1_row_ff    <= cr;
         s1_border_ff <= border_s0;
         fwd_ff       <= fwd_in;
         fwd_data_ff  <= wr_word;
      end
      if (reset) begin
         width_ff    <= WID_W'(blo_pkg::RESET_WIDTH > MAX_WIDTH ? MAX_WIDTH
                                                                : blo_pkg::RESET_WIDTH);
         height_ff   <= blo_pkg::RESET_HEIGHT;
         enable_ff   <= en_reset_wide[LABEL_BITS-1:0];
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         enable_ff   <= enable_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   blo_ram #(
      .WIDTH(WORD_W),
      .DEPTH(MAX_WIDTH)
   ) u_line_ram (
      .clock  (clock),
      .wr_en  (s1_fire),
      .wr_addr(s1_addr_ff),
      .wr_data(wr_word),
      .rd_en  (accept),
      .rd_addr(col_ff),
      .rd_data(rd_word)
   );

   blo_outline #(
      .LABEL_BITS(LABEL_BITS),
      .COL_W     (COL_W)
   ) u_outline (
      .clock           (clock),
      .reset           (reset),
      .fire            (s1_fire),
      .border          (s1_border_ff),
      .col             (s1_col_ff),
      .row             (s1_row_ff),
      .enable          (enable_ff),
      .south           (old_word[WORD_W-1:LABEL_BITS]),
      .centre          (old_word[LABEL_BITS-1:0]),
      .north           (s1_value_ff),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_pixel_col   (rsp_pixel_col),
      .rsp_pixel_row   (rsp_pixel_row),
      .rsp_edge_flags  (rsp_edge_flags),
      .rsp_corner_flags(rsp_corner_flags),
      .rsp_frame_last  (rsp_frame_last),
      .out_free        (out_free)
   );

   `ASSERT_HOLDS(a_col_in_row, clock, reset, WID_W'(col_ff) < width_ff)
   `ASSERT_HOLDS(a_row_bound, clock, reset, row_ff <= ROW_W'(height_ff) + ROW_W'(1))
   `ASSERT_IMPLIES(a_emit_has_room, clock, reset, s1_fire && s1_border_ff.emit, !rsp_valid || !rsp_stall)

endmodule

// ===== sv/blo_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module blo_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/blo_outline.sv =====
// 3x3 window registers, per-label edge and corner flags, and result register.
module blo_outline #(
   parameter int LABEL_BITS = blo_pkg::DEF_LABEL_BITS,
   parameter int COL_W      = 10
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          fire,
   input  blo_pkg::border_type                           border,
   input  logic [COL_W-1:0]                              col,
   input  logic [blo_pkg::IMAGE_HEIGHT_W-1:0]            row,
   input  logic [LABEL_BITS-1:0]                         enable,
   input  logic [LABEL_BITS-1:0]                         south,
   input  logic [LABEL_BITS-1:0]                         centre,
   input  logic [LABEL_BITS-1:0]                         north,
   input  logic                                          rsp_stall,
   output logic                                          rsp_valid,
   output logic [COL_W-1:0]                              rsp_pixel_col,
   output logic [blo_pkg::IMAGE_HEIGHT_W-1:0]            rsp_pixel_row,
   output logic [blo_pkg::FLAGS_PER_LABEL*LABEL_BITS-1:0] rsp_edge_flags,
   output logic [blo_pkg::FLAGS_PER_LABEL*LABEL_BITS-1:0] rsp_corner_flags,
   output logic                                          rsp_frame_last,
   output logic                                          out_free
);

   localparam int FLAG_W = blo_pkg::FLAGS_PER_LABEL * LABEL_BITS;
   localparam int WEST = 0, MID = 1, EAST = 2;
   localparam int LVL_S = 0, LVL_C = 1, LVL_N = 2;

   logic [LABEL_BITS-1:0] win_ff [3][3];
   logic [LABEL_BITS-1:0] win_in [3][3];

   logic                              valid_ff, valid_in;
   logic [COL_W-1:0]                  col_ff;
   logic [blo_pkg::IMAGE_HEIGHT_W-1:0] row_ff;
   logic [FLAG_W-1:0]                 edges_ff, edges_in;
   logic [FLAG_W-1:0]                 corners_ff, corners_in;
   logic                              last_ff;

   always_comb begin
      win_in = win_ff;
      if (fire) begin
         for (int i = 0; i < 3; i++) begin
            win_in[WEST][i] = win_ff[MID][i];
            win_in[MID][i]  = win_ff[EAST][i];
         end
         win_in[EAST][LVL_S] = south;
         win_in[EAST][LVL_C] = centre;
         win_in[EAST][LVL_N] = north;
      end
   end

   always_comb begin
      logic [LABEL_BITS-1:0] ctr, ns, nn, nw, ne, nsw, nse, nnw, nne;
      logic                  s, w, e, n;
      ctr = win_in[MID][LVL_C];
      ns  = border.has_s ? win_in[MID][LVL_S] : '0;
      nn  = border.has_n ? win_in[MID][LVL_N] : '0;
      nw  = border.has_w ? win_in[WEST][LVL_C] : '0;
      ne  = border.has_e ? win_in[EAST][LVL_C] : '0;
      nsw = (border.has_s && border.has_w) ? win_in[WEST][LVL_S] : '0;
      nse = (border.has_s && border.has_e) ? win_in[EAST][LVL_S] : '0;
      nnw = (border.has_n && border.has_w) ? win_in[WEST][LVL_N] : '0;
      nne = (border.has_n && border.has_e) ? win_in[EAST][LVL_N] : '0;
      edges_in   = '0;
      corners_in = '0;
      for (int k = 0; k < LABEL_BITS; k++) begin
         s = ns[k];
         w = nw[k];
         e = ne[k];
         n = nn[k];
         if (ctr[k] && enable[k]) begin
            edges_in[4*k +: 4]   = {~n, ~e, ~w, ~s};
            corners_in[4*k +: 4] = {~n | ~e | ~nne[k], ~n | ~w | ~nnw[k],
                                    ~s | ~e | ~nse[k], ~s | ~w | ~nsw[k]};
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (fire && border.emit) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      if (fire && border.emit) begin
         col_ff     <= col;
         row_ff     <= row;
         edges_ff   <= edges_in;
         corners_ff <= corners_in;
         last_ff    <= border.last;
      end
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign out_free         = !valid_ff || !rsp_stall;
   assign rsp_valid        = valid_ff;
   assign rsp_pixel_col    = col_ff;
   assign rsp_pixel_row    = row_ff;
   assign rsp_edge_flags   = edges_ff;
   assign rsp_corner_flags = corners_ff;
   assign rsp_frame_last   = last_ff;

endmodule
